/* hw/rtl/wfaf_pkg.sv */
// shared types and constants for the 802.11 address filter and frame counter
package wfaf_pkg;

  localparam int unsigned MaxStationsDef = 8;
  localparam int unsigned CountWidthDef  = 32;

  localparam int unsigned MacW    = 48;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 12;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RxCntW  = 32;

  typedef logic [MacW-1:0] mac_t;
  typedef logic [PosW-1:0] pos_t;

  // header byte positions
  localparam pos_t PosFcHigh  = 5'd1;
  localparam pos_t PosAddr1   = 5'd4;
  localparam pos_t PosAddr2   = 5'd10;
  localparam pos_t PosAddr3   = 5'd16;
  localparam pos_t PosHdrEnd  = 5'd22;
  localparam pos_t PosSat     = 5'd24;

  // ToDS and FromDS inside the high frame control byte
  localparam int unsigned FcToDsBit   = 0;
  localparam int unsigned FcFromDsBit = 1;

  localparam logic [LenW-1:0] MinCaptureLen = 12'd10;
  localparam logic [LenW-1:0] MinHeaderLen  = 12'd24;

  typedef enum logic [1:0] {
    OP_FRAME_BYTE    = 2'd0,
    OP_STATION_WRITE = 2'd1,
    OP_CLEAR_COUNT   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_MGMT = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_DATA = 2'd2,
    KIND_MISC = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_ALL     = 2'd0,
    MODE_BSSID   = 2'd1,
    MODE_STATION = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILTER_MODE   = 2'd0,
    CFG_FILTER_BSSID  = 2'd1,
    CFG_STATION_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ByteW-1:0] frame_byte;
    logic            frame_last;
    logic [1:0]      frame_kind;
    logic [LenW-1:0] frame_length;
    logic [2:0]      entry_index;
    mac_t            entry_address;
  } in_item_t;

  typedef struct packed {
    logic              frame_counted;
    logic              capture_accept;
    logic [RxCntW-1:0] received_count;
  } out_item_t;

  // header as seen after the current byte
  typedef struct packed {
    logic to_ds;
    logic from_ds;
    mac_t addr1;
    mac_t addr2;
    mac_t addr3;
  } hdr_t;

  typedef struct packed {
    logic known_a;
    logic known_b;
  } sta_match_t;

endpackage

/* hw/rtl/wfaf_capture.sv */
// header capture: byte position, ds bits and the three addresses
module wfaf_capture (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           byte_en_i,
  input  logic [wfaf_pkg::ByteW-1:0]     frame_byte_i,
  input  logic                           frame_last_i,
  output wfaf_pkg::hdr_t                 hdr_o
);

  wfaf_pkg::pos_t pos_q, pos_d;
  wfaf_pkg::hdr_t hdr_q, hdr_d, view;

  always_comb begin
    view = hdr_q;
    if (pos_q == wfaf_pkg::PosFcHigh) begin
      view.to_ds   = frame_byte_i[wfaf_pkg::FcToDsBit];
      view.from_ds = frame_byte_i[wfaf_pkg::FcFromDsBit];
    end
    if (pos_q >= wfaf_pkg::PosAddr1 && pos_q < wfaf_pkg::PosAddr2) begin
      view.addr1 = {hdr_q.addr1[wfaf_pkg::MacW-wfaf_pkg::ByteW-1:0], frame_byte_i};
    end
    if (pos_q >= wfaf_pkg::PosAddr2 && pos_q < wfaf_pkg::PosAddr3) begin
      view.addr2 = {hdr_q.addr2[wfaf_pkg::MacW-wfaf_pkg::ByteW-1:0], frame_byte_i};
    end
    if (pos_q >= wfaf_pkg::PosAddr3 && pos_q < wfaf_pkg::PosHdrEnd) begin
      view.addr3 = {hdr_q.addr3[wfaf_pkg::MacW-wfaf_pkg::ByteW-1:0], frame_byte_i};
    end
  end

  assign hdr_o = view;

  always_comb begin
    pos_d = pos_q;
    hdr_d = hdr_q;
    if (byte_en_i) begin
      if (frame_last_i) begin
        pos_d = '0;
        hdr_d = '0;
      end else begin
        hdr_d = view;
        if (pos_q < wfaf_pkg::PosSat) begin
          pos_d = pos_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
    end else begin
      pos_q <= pos_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

/* hw/rtl/wfaf_station_table.sv */
// station address table with parallel lookup of two addresses
module wfaf_station_table #(
  parameter int unsigned MaxStations = wfaf_pkg::MaxStationsDef
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [2:0]           widx_i,
  input  wfaf_pkg::mac_t       wdata_i,
  input  logic [3:0]           station_count_i,
  input  wfaf_pkg::mac_t       addr_a_i,
  input  wfaf_pkg::mac_t       addr_b_i,
  output wfaf_pkg::sta_match_t match_o
);

  wfaf_pkg::mac_t sta_q [MaxStations];

  for (genvar g = 0; g < MaxStations; g++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (we_i && (int'(widx_i) == g)) begin
        sta_q[g] <= wdata_i;
      end
    end
  end

  always_comb begin
    match_o = '0;
    for (int i = 0; i < MaxStations; i++) begin
      if (int'(station_count_i) > i) begin
        if (sta_q[i] == addr_a_i) match_o.known_a = 1'b1;
        if (sta_q[i] == addr_b_i) match_o.known_b = 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/wifi_frame_address_filter_counter_top.sv */
// top level of the 802.11 address filter and received frame counter
// the result register takes each result as its last byte leaves the input register
// throughput: one item per cycle unless stalled, set by the single input to result
// register pass; frame bytes, station writes and count clears all take one slot
// reset: asynchronous active low, clears header capture, counter, config and valids
// the station table is not cleared and holds whatever was last written
module wifi_frame_address_filter_counter_top #(
  parameter int unsigned MaxStations = wfaf_pkg::MaxStationsDef,
  parameter int unsigned CountWidth  = wfaf_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wfaf_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wfaf_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wfaf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wfaf_pkg::MacW-1:0]     cfg_data_i
);

  logic [1:0]            filter_mode_q;
  wfaf_pkg::mac_t        filter_bssid_q;
  logic [3:0]            station_count_q;

  logic                  in_valid_q;
  wfaf_pkg::in_item_t    in_q;
  logic                  advance;
  logic                  is_frame, is_write, is_clear, is_result;

  wfaf_pkg::hdr_t        hdr;
  wfaf_pkg::sta_match_t  sta_match;
  wfaf_pkg::mac_t        bssid, sta_a, sta_b;
  logic                  has_b, wds, hdr_ok, accept, match, counted;

  logic [CountWidth-1:0] count_q, count_d;
  logic [63:0]           count_ext;

  logic                  out_valid_q;
  wfaf_pkg::out_item_t   out_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q   <= '0;
      filter_bssid_q  <= '0;
      station_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wfaf_pkg::CFG_FILTER_MODE:   filter_mode_q   <= cfg_data_i[1:0];
        wfaf_pkg::CFG_FILTER_BSSID:  filter_bssid_q  <= cfg_data_i;
        wfaf_pkg::CFG_STATION_COUNT: station_count_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign is_frame  = advance && (in_q.operation == wfaf_pkg::OP_FRAME_BYTE);
  assign is_write  = advance && (in_q.operation == wfaf_pkg::OP_STATION_WRITE);
  assign is_clear  = advance && (in_q.operation == wfaf_pkg::OP_CLEAR_COUNT);
  assign is_result = is_frame && in_q.frame_last;

  wfaf_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (is_frame),
    .frame_byte_i (in_q.frame_byte),
    .frame_last_i (in_q.frame_last),
    .hdr_o        (hdr)
  );

  // address roles from ToDS and FromDS
  always_comb begin
    bssid = hdr.addr3;
    sta_a = hdr.addr1;
    sta_b = hdr.addr2;
    has_b = 1'b0;
    wds   = 1'b0;
    unique case ({hdr.to_ds, hdr.from_ds})
      2'b10: begin
        bssid = hdr.addr1;
        sta_a = hdr.addr2;
      end
      2'b01: begin
        bssid = hdr.addr2;
        sta_a = hdr.addr1;
      end
      2'b00: begin
        bssid = hdr.addr3;
        sta_a = hdr.addr1;
        sta_b = hdr.addr2;
        has_b = 1'b1;
      end
      default: begin
        wds = 1'b1;
      end
    endcase
  end

  wfaf_station_table #(
    .MaxStations (MaxStations)
  ) u_station_table (
    .clk_i           (clk_i),
    .we_i            (is_write),
    .widx_i          (in_q.entry_index),
    .wdata_i         (in_q.entry_address),
    .station_count_i (station_count_q),
    .addr_a_i        (sta_a),
    .addr_b_i        (sta_b),
    .match_o         (sta_match)
  );

  assign accept = ((in_q.frame_kind == wfaf_pkg::KIND_MGMT) ||
                   (in_q.frame_kind == wfaf_pkg::KIND_DATA)) &&
                  (in_q.frame_length >= wfaf_pkg::MinCaptureLen);
  assign hdr_ok = !wds && (in_q.frame_length >= wfaf_pkg::MinHeaderLen) &&
                  (bssid == filter_bssid_q);

  always_comb begin
    unique case (filter_mode_q)
      wfaf_pkg::MODE_ALL:     match = 1'b1;
      wfaf_pkg::MODE_BSSID:   match = hdr_ok;
      wfaf_pkg::MODE_STATION: match = hdr_ok &&
                                      (sta_match.known_a || (has_b && sta_match.known_b));
      default:                match = 1'b0;
    endcase
  end

  assign counted = accept && match;

  // received frame counter, wraps
  always_comb begin
    count_d = count_q;
    if (is_clear) begin
      count_d = '0;
    end else if (is_result && counted) begin
      count_d = count_q + {{(CountWidth-1){1'b0}}, 1'b1};
    end
  end

  assign count_ext = 64'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_result) begin
      out_q.frame_counted  <= counted;
      out_q.capture_accept <= accept;
      out_q.received_count <= count_ext[wfaf_pkg::RxCntW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/frame_count_checker.sv */
// checker that predicts filter verdicts from observed transfers and compares each result
`timescale 1ns / 100ps
module frame_count_checker
  import wfaf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MacW-1:0]    cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam int unsigned TableDepth = MaxStationsDef;

  logic [1:0]        mode_q;
  mac_t              bssid_q;
  logic [3:0]        sta_count_q;
  pos_t              pos_q;
  logic [15:0]       fc_q;
  mac_t              addr1_q;
  mac_t              addr2_q;
  mac_t              addr3_q;
  mac_t              sta_table_q [TableDepth];
  logic [RxCntW-1:0] rx_count_q;
  out_item_t         pending_verdicts [$];
  int unsigned       errors = 0;

  assign fail_count_o = errors;

  function automatic logic station_listed(mac_t mac);
    int unsigned n;
    int unsigned i;
    n = (sta_count_q > TableDepth) ? TableDepth : sta_count_q;
    for (i = 0; i < n; i++) begin
      if (sta_table_q[i] == mac) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic frame_passes(logic [LenW-1:0] len);
    logic to_ds;
    logic from_ds;
    logic has_b;
    mac_t bssid;
    mac_t sta_a;
    mac_t sta_b;
    to_ds   = fc_q[8 + FcToDsBit];
    from_ds = fc_q[8 + FcFromDsBit];
    has_b   = 1'b0;
    sta_b   = '0;
    if (mode_q == MODE_ALL) return 1'b1;
    if (len < MinHeaderLen) return 1'b0;
    case ({to_ds, from_ds})
      2'b10: begin
        bssid = addr1_q;
        sta_a = addr2_q;
      end
      2'b01: begin
        bssid = addr2_q;
        sta_a = addr1_q;
      end
      2'b00: begin
        bssid = addr3_q;
        sta_a = addr1_q;
        sta_b = addr2_q;
        has_b = 1'b1;
      end
      // wds frames carry four addresses and are never counted here
      default: return 1'b0;
    endcase
    if (bssid != bssid_q) return 1'b0;
    if (mode_q == MODE_BSSID) return 1'b1;
    if (mode_q == MODE_STATION) return station_listed(sta_a) || (has_b && station_listed(sta_b));
    return 1'b0;
  endfunction

  task automatic absorb_rx_item(in_item_t item);
    out_item_t verdict;
    logic      accept;
    case (item.operation)
      OP_STATION_WRITE: sta_table_q[item.entry_index] = item.entry_address;
      OP_CLEAR_COUNT:   rx_count_q = '0;
      OP_FRAME_BYTE: begin
        if (pos_q == '0) begin
          fc_q = {8'h00, item.frame_byte};
        end else if (pos_q == PosFcHigh) begin
          fc_q[15:8] = item.frame_byte;
        end else if (pos_q >= PosAddr1 && pos_q < PosAddr2) begin
          addr1_q = {addr1_q[MacW-9:0], item.frame_byte};
        end else if (pos_q >= PosAddr2 && pos_q < PosAddr3) begin
          addr2_q = {addr2_q[MacW-9:0], item.frame_byte};
        end else if (pos_q >= PosAddr3 && pos_q < PosHdrEnd) begin
          addr3_q = {addr3_q[MacW-9:0], item.frame_byte};
        end
        if (pos_q < PosSat) pos_q = pos_q + 1'b1;
        if (item.frame_last) begin
          accept = (item.frame_kind == KIND_MGMT || item.frame_kind == KIND_DATA) &&
                   item.frame_length >= MinCaptureLen;
          verdict.frame_counted = accept && frame_passes(item.frame_length);
          if (verdict.frame_counted) rx_count_q = rx_count_q + 1'b1;
          verdict.capture_accept = accept;
          verdict.received_count = rx_count_q;
          pending_verdicts.push_back(verdict);
          pos_q   = '0;
          fc_q    = '0;
          addr1_q = '0;
          addr2_q = '0;
          addr3_q = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic apply_cfg_write(logic [CfgIdxW-1:0] idx, mac_t data);
    case (idx)
      CFG_FILTER_MODE:   mode_q = data[1:0];
      CFG_FILTER_BSSID:  bssid_q = data;
      CFG_STATION_COUNT: sta_count_q = data[3:0];
      default: ;
    endcase
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_verdicts.size() == 0) begin
      $error("result transfer with none expected: frame_counted %0d capture_accept %0d received_count %0d",
             got.frame_counted, got.capture_accept, got.received_count);
      errors++;
    end else begin
      want = pending_verdicts.pop_front();
      if (got.frame_counted !== want.frame_counted) begin
        $error("frame_counted expected %0d actual %0d", want.frame_counted, got.frame_counted);
        errors++;
      end
      if (got.capture_accept !== want.capture_accept) begin
        $error("capture_accept expected %0d actual %0d", want.capture_accept, got.capture_accept);
        errors++;
      end
      if (got.received_count !== want.received_count) begin
        $error("received_count expected %0d actual %0d", want.received_count, got.received_count);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      = MODE_ALL;
      bssid_q     = '0;
      sta_count_q = '0;
      pos_q       = '0;
      fc_q        = '0;
      addr1_q     = '0;
      addr2_q     = '0;
      addr3_q     = '0;
      rx_count_q  = '0;
      pending_verdicts.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) apply_cfg_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) absorb_rx_item(in_data_i);
      pending_o <= pending_verdicts.size();
    end
  end

endmodule

/* tb/tb_wifi_frame_address_filter_counter_top.sv */
// testbench top: drives frames, station writes and filter settings, and reports the verdict
`timescale 1ns / 100ps
module tb_wifi_frame_address_filter_counter_top;
  import wfaf_pkg::*;

  localparam int unsigned RandomItems  = 1350;
  localparam int unsigned PhaseItems   = 110;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned StationSlots = MaxStationsDef;
  localparam logic [1:0]         OpReserved   = 2'd3;
  localparam logic [1:0]         ModeReserved = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  mac_t               cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  int unsigned stim_count = 0;
  int unsigned send_gap_max = 0;
  int unsigned sink_stall_max = 0;
  bit          hold_long = 1'b0;
  mac_t        bssid_cur = '0;
  mac_t        station_mac [StationSlots];

  always #4 clk = ~clk;

  wifi_frame_address_filter_counter_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  frame_count_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  function automatic mac_t rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic mac_t pick_mac();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return bssid_cur;
    if (r < 85) return station_mac[$urandom_range(StationSlots - 1)];
    return rand_mac();
  endfunction

  function automatic logic [ByteW-1:0] mac_byte(mac_t mac, int unsigned k);
    return 8'(mac >> (8 * (5 - k)));
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.operation     = 2'($urandom);
    it.frame_byte    = 8'($urandom);
    it.frame_last    = 1'($urandom);
    it.frame_kind    = 2'($urandom);
    it.frame_length  = 12'($urandom);
    it.entry_index   = 3'($urandom);
    it.entry_address = rand_mac();
    return it;
  endfunction

  task automatic send_rx_item(in_item_t item);
    int unsigned gap;
    gap = $urandom_range(send_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.operation != OpReserved) stim_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, mac_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(logic [1:0] mode, mac_t bssid, logic [3:0] count);
    mac_t junk;
    wait_idle();
    junk = rand_mac();
    write_cfg(CFG_FILTER_MODE, {junk[MacW-1:2], mode});
    write_cfg(CFG_FILTER_BSSID, bssid);
    junk = rand_mac();
    write_cfg(CFG_STATION_COUNT, {junk[MacW-1:4], count});
    if ($urandom_range(3) == 0) write_cfg(CfgIdxUnused, rand_mac());
    bssid_cur = bssid;
  endtask

  task automatic send_op(logic [1:0] op);
    in_item_t it;
    it = noise_item();
    it.operation = op;
    send_rx_item(it);
  endtask

  task automatic send_station(int unsigned idx, mac_t mac);
    in_item_t it;
    it = noise_item();
    it.operation     = OP_STATION_WRITE;
    it.entry_index   = 3'(idx);
    it.entry_address = mac;
    station_mac[idx] = mac;
    send_rx_item(it);
  endtask

  task automatic send_side_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_station($urandom_range(StationSlots - 1), ($urandom_range(1) != 0) ? rand_mac() : pick_mac());
    end else if (r < 70) begin
      send_op(OP_CLEAR_COUNT);
    end else begin
      send_op(OpReserved);
    end
  endtask

  task automatic send_frame(int unsigned nbytes, kind_e kind, logic [LenW-1:0] len,
                            logic [1:0] ds, mac_t a1, mac_t a2, mac_t a3);
    in_item_t    it;
    int unsigned i;
    for (i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < 3) send_side_item();
      it = noise_item();
      it.operation    = OP_FRAME_BYTE;
      it.frame_kind   = kind;
      it.frame_length = len;
      it.frame_last   = (i == nbytes - 1);
      if (i == PosFcHigh) begin
        it.frame_byte[FcToDsBit]   = ds[0];
        it.frame_byte[FcFromDsBit] = ds[1];
      end else if (i >= PosAddr1 && i < PosAddr2) begin
        it.frame_byte = mac_byte(a1, i - PosAddr1);
      end else if (i >= PosAddr2 && i < PosAddr3) begin
        it.frame_byte = mac_byte(a2, i - PosAddr2);
      end else if (i >= PosAddr3 && i < PosHdrEnd) begin
        it.frame_byte = mac_byte(a3, i - PosAddr3);
      end
      send_rx_item(it);
    end
  endtask

  task automatic random_frame();
    int unsigned     r;
    int unsigned     nbytes;
    kind_e           kind;
    logic [LenW-1:0] len;
    r = $urandom_range(99);
    if (r < 60) nbytes = $urandom_range(30, 22);
    else if (r < 85) nbytes = $urandom_range(21, 1);
    else nbytes = $urandom_range(40, 31);
    r = $urandom_range(99);
    if (r < 60) len = 12'($urandom_range(60, 24));
    else if (r < 70) len = 12'($urandom_range(4095, 61));
    else if (r < 80) len = 12'($urandom_range(23, 10));
    else if (r < 90) len = 12'($urandom_range(9, 0));
    else len = 12'(nbytes);
    r = $urandom_range(99);
    if (r < 40) kind = KIND_MGMT;
    else if (r < 80) kind = KIND_DATA;
    else if (r < 90) kind = KIND_CTRL;
    else kind = KIND_MISC;
    send_frame(nbytes, kind, len, 2'($urandom), pick_mac(), pick_mac(), pick_mac());
  endtask

  task automatic run_phase(int unsigned p);
    int unsigned budget;
    int unsigned i;
    case (p)
      0: set_filter(MODE_BSSID, '1, 4'd0);
      1: set_filter(MODE_STATION, '0, 4'd8);
      2: set_filter(MODE_STATION, rand_mac(), 4'd15);
      3: set_filter(ModeReserved, rand_mac(), 4'd1);
      4: set_filter(MODE_ALL, rand_mac(), 4'd9);
      default: set_filter(2'($urandom), rand_mac(), 4'($urandom));
    endcase
    if (p == 2) begin
      // receiver stalls long while short frames keep coming, so the block backs up
      send_gap_max = 0;
      hold_long = 1'b1;
      for (i = 0; i < 48; i++) begin
        send_frame(1, KIND_DATA, 12'($urandom_range(4095, 10)), 2'($urandom),
                   pick_mac(), pick_mac(), pick_mac());
      end
    end
    send_gap_max   = ($urandom_range(1) != 0) ? 4 : 0;
    sink_stall_max = ($urandom_range(1) != 0) ? 4 : 0;
    budget = stim_count + PhaseItems;
    while (stim_count < budget) begin
      if ($urandom_range(99) < 8) send_side_item();
      else random_frame();
    end
  endtask

  initial begin : sink
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        stall = $urandom_range(sink_stall_max);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("wifi_frame_address_filter_counter_top test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // load every station slot before any lookup can reach the table
    for (i = 0; i < StationSlots; i++) begin
      if (i == 0) send_station(i, '0);
      else if (i == StationSlots - 1) send_station(i, '1);
      else send_station(i, rand_mac());
    end
    send_op(OpReserved);
    send_op(OP_CLEAR_COUNT);
    send_frame(1, KIND_CTRL, 12'd4095, 2'b00, '0, '0, '0);
    send_frame(1, KIND_MISC, 12'd100, 2'b00, '0, '0, '0);
    send_frame(1, KIND_MGMT, 12'd9, 2'b00, '0, '0, '0);
    send_frame(1, KIND_DATA, 12'd10, 2'b00, '0, '0, '0);
    send_frame(1, KIND_MGMT, 12'd0, 2'b00, '0, '0, '0);
    send_frame(2, KIND_DATA, 12'd4095, 2'b11, '0, '0, '0);
    send_op(OP_CLEAR_COUNT);
    send_frame(1, KIND_DATA, 12'd24, 2'b00, '0, '0, '0);
    stim_count = 0;
    phase = 0;
    while (stim_count < RandomItems) begin
      run_phase(phase);
      phase++;
    end
    wait_idle();
    if (fail_count == 0 && pending_results == 0) begin
      $display("wifi_frame_address_filter_counter_top test passed");
    end else begin
      $display("wifi_frame_address_filter_counter_top test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/wfaf_pkg.sv
hw/rtl/wfaf_capture.sv
hw/rtl/wfaf_station_table.sv
hw/rtl/wifi_frame_address_filter_counter_top.sv
tb/frame_count_checker.sv
tb/tb_wifi_frame_address_filter_counter_top.sv
